// File: design/iate_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iate_pkg: shared types and constants
// Opcodes, status codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package iate_pkg;
  localparam int Depth = 16;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam logic [4:0] CapReset = 5'd10;

  typedef enum logic [3:0] {
    OP_APPEND = 4'd0, OP_INSERT = 4'd1, OP_DELETE = 4'd2, OP_GET = 4'd3,
    OP_SET = 4'd4, OP_LSEARCH = 4'd5, OP_BSEARCH = 4'd6, OP_SINSERT = 4'd7,
    OP_SUM = 4'd8, OP_MAX = 4'd9, OP_MIN = 4'd10, OP_REVERSE = 4'd11
  } opcode_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_SWAP, S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [4:0]  position;
    logic [31:0] element_value;
    logic [31:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  found_position;
    logic [4:0]  current_length;
    logic [1:0]  status;
  } out_item_t;
endpackage
`default_nettype wire

// File: design/iate_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iate_in_if / iate_out_if: valid-ready channels
// One transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface iate_in_if;
  logic valid;
  logic ready;
  iate_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iate_out_if;
  logic valid;
  logic ready;
  iate_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/indexed_array_table_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_table_engine: array ADT engine
// Sixteen-entry signed array with insert, delete, search, sum, max, min,
// reverse, driven by a small sequencer over compare and add logic.
// ----------------------------------------------------------------------------
// Usage: one transaction in, one transaction out. The block takes one item at
// a time; ready drops from accept until the result transaction is handed over,
// and comes back in the cycle after that handover. Get, set, append and
// refused operations go straight from the run state to done; shifting,
// linear search, sum, max, min and sorted insert step one element per cycle,
// reverse swaps one pair of elements from both ends per step, and binary
// search halves its range per step. A linear-search hit passes through a
// swap state that exchanges it with element 0. The next item can thus be
// accepted only after the result of the last one has been handed over.
// capacity is written through cfg_we/cfg_wdata; the user must write it only
// while idle, the block does not enforce it. Values above 16 act as 16 and zero makes the array full.
module indexed_array_table_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  iate_in_if.sink          in_ch,
  iate_out_if.source       out_ch
);
  logic [31:0] mem [iate_pkg::Depth];
  logic [4:0]  cap_r;
  logic [4:0]  cnt_r, cnt_nxt;
  iate_pkg::state_t st_r, st_nxt;
  iate_pkg::in_item_t it_r, it_nxt;
  logic [4:0]  i_r, i_nxt;       // walking index
  logic [4:0]  j_r, j_nxt;       // second index (hi / b)
  logic [31:0] acc_r, acc_nxt;   // sum / max / min / carried value
  logic [31:0] tmp_r, tmp_nxt;
  logic        ov_r, ov_nxt;
  iate_pkg::out_item_t res_r, res_nxt;

  logic        we_a, we_b;
  logic [3:0]  wa_a, wa_b;
  logic [31:0] wd_a, wd_b;

  logic [4:0]  ecap;
  logic        full;
  logic [31:0] rd_i, rd_j, rd_m, rd_im1;
  logic [4:0]  mid;
  logic        lt_ki, lt_vi;

  assign ecap = (cap_r > 5'd16) ? 5'd16 : cap_r;
  assign full = cnt_r >= ecap;
  assign mid = 5'((6'(i_r) + 6'(j_r)) >> 1);
  assign rd_i = mem[i_r[3:0]];
  assign rd_j = mem[j_r[3:0]];
  assign rd_m = mem[mid[3:0]];
  assign rd_im1 = mem[4'(i_r - 5'd1)];
  assign lt_ki = $signed(it_r.search_key) < $signed(rd_m);
  assign lt_vi = $signed(it_r.element_value) < $signed(rd_im1);

  assign in_ch.ready = (st_r == iate_pkg::S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= iate_pkg::CapReset;
      cnt_r <= '0;
      st_r <= iate_pkg::S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      cnt_r <= cnt_nxt;
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    acc_r <= acc_nxt;
    tmp_r <= tmp_nxt;
    res_r <= res_nxt;
    if (we_a) mem[wa_a] <= wd_a;
    if (we_b) mem[wa_b] <= wd_b;
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    it_nxt = it_r;
    i_nxt = i_r;
    j_nxt = j_r;
    acc_nxt = acc_r;
    tmp_nxt = tmp_r;
    res_nxt = res_r;
    ov_nxt = ov_r && !out_ch.ready;
    we_a = 1'b0; wa_a = '0; wd_a = '0;
    we_b = 1'b0; wa_b = '0; wd_b = '0;
    case (st_r)
      iate_pkg::S_IDLE: begin
        if (in_ch.valid && !ov_r) begin
          it_nxt = in_ch.data;
          st_nxt = iate_pkg::S_RUN;
          res_nxt = '0;
          acc_nxt = '0;
          i_nxt = '0;
          j_nxt = cnt_r - 5'd1;
          // Prepare per-op start indices.
          case (in_ch.data.opcode)
            iate_pkg::OP_INSERT, iate_pkg::OP_SINSERT: i_nxt = cnt_r;
            iate_pkg::OP_DELETE: i_nxt = in_ch.data.position;
            iate_pkg::OP_MAX, iate_pkg::OP_MIN: i_nxt = 5'd1;
            default: ;
          endcase
        end
      end
      iate_pkg::S_RUN: begin
        st_nxt = iate_pkg::S_DONE;
        res_nxt.current_length = cnt_r;
        case (it_r.opcode)
          iate_pkg::OP_APPEND: begin
            if (full) res_nxt.status = iate_pkg::ST_FULL;
            else begin
              we_a = 1'b1; wa_a = cnt_r[3:0]; wd_a = it_r.element_value;
              cnt_nxt = cnt_r + 5'd1;
              res_nxt.current_length = cnt_nxt;
            end
          end
          iate_pkg::OP_INSERT: begin
            if (full) res_nxt.status = iate_pkg::ST_FULL;
            else if (it_r.position > cnt_r) res_nxt.status = iate_pkg::ST_RANGE;
            else if (i_r > it_r.position) begin
              // Shift one element up per cycle, from the top down.
              we_a = 1'b1; wa_a = i_r[3:0]; wd_a = rd_im1;
              i_nxt = i_r - 5'd1;
              st_nxt = iate_pkg::S_RUN;
            end else begin
              we_a = 1'b1; wa_a = i_r[3:0]; wd_a = it_r.element_value;
              cnt_nxt = cnt_r + 5'd1;
              res_nxt.current_length = cnt_nxt;
            end
          end
          iate_pkg::OP_SINSERT: begin
            if (full) res_nxt.status = iate_pkg::ST_FULL;
            else if (i_r != 5'd0 && lt_vi) begin
              we_a = 1'b1; wa_a = i_r[3:0]; wd_a = rd_im1;
              i_nxt = i_r - 5'd1;
              st_nxt = iate_pkg::S_RUN;
            end else begin
              we_a = 1'b1; wa_a = i_r[3:0]; wd_a = it_r.element_value;
              cnt_nxt = cnt_r + 5'd1;
              res_nxt.current_length = cnt_nxt;
            end
          end
          iate_pkg::OP_DELETE: begin
            if (it_r.position >= cnt_r) res_nxt.status = iate_pkg::ST_RANGE;
            else begin
              // Capture the victim on the first step, then shift down.
              if (i_r == it_r.position) res_nxt.result_value = rd_i;
              else res_nxt.result_value = res_r.result_value;
              if (i_r + 5'd1 < cnt_r) begin
                we_a = 1'b1; wa_a = i_r[3:0]; wd_a = mem[4'(i_r + 5'd1)];
                i_nxt = i_r + 5'd1;
                st_nxt = iate_pkg::S_RUN;
              end else begin
                cnt_nxt = cnt_r - 5'd1;
                res_nxt.current_length = cnt_nxt;
              end
            end
          end
          iate_pkg::OP_GET: begin
            if (it_r.position < cnt_r) res_nxt.result_value = mem[it_r.position[3:0]];
            else begin
              res_nxt.result_value = '1;
              res_nxt.status = iate_pkg::ST_RANGE;
            end
          end
          iate_pkg::OP_SET: begin
            if (it_r.position < cnt_r) begin
              we_a = 1'b1; wa_a = it_r.position[3:0]; wd_a = it_r.element_value;
            end else res_nxt.status = iate_pkg::ST_RANGE;
          end
          iate_pkg::OP_LSEARCH: begin
            if (i_r >= cnt_r) begin
              res_nxt.status = iate_pkg::ST_RANGE;
              res_nxt.found_position = '1;
            end else if (rd_i == it_r.search_key) begin
              res_nxt.found_position = i_r;
              tmp_nxt = rd_i;
              st_nxt = iate_pkg::S_SWAP;
            end else begin
              i_nxt = i_r + 5'd1;
              st_nxt = iate_pkg::S_RUN;
            end
          end
          iate_pkg::OP_BSEARCH: begin
            // i_r is lo, j_r is hi; hi goes "negative" as 5'h1F past zero.
            if (j_r[4] || i_r > j_r) begin
              res_nxt.status = iate_pkg::ST_RANGE;
              res_nxt.found_position = '1;
            end else if (rd_m == it_r.search_key) begin
              res_nxt.found_position = mid;
            end else begin
              if (lt_ki) j_nxt = mid - 5'd1;
              else i_nxt = mid + 5'd1;
              st_nxt = iate_pkg::S_RUN;
            end
          end
          iate_pkg::OP_SUM: begin
            if (i_r < cnt_r) begin
              acc_nxt = acc_r + rd_i;
              i_nxt = i_r + 5'd1;
              st_nxt = iate_pkg::S_RUN;
            end else res_nxt.result_value = acc_r;
          end
          iate_pkg::OP_MAX, iate_pkg::OP_MIN: begin
            if (cnt_r == 5'd0) res_nxt.status = iate_pkg::ST_FULL;
            else begin
              if (i_r == 5'd1) acc_nxt = mem[0];
              // On the first step acc_r is stale; compare against element 0.
              if (i_r < cnt_r) begin
                if ((it_r.opcode == iate_pkg::OP_MAX) ?
                    ($signed(acc_nxt) < $signed(rd_i)) :
                    ($signed(rd_i) < $signed(acc_nxt)))
                  acc_nxt = rd_i;
                i_nxt = i_r + 5'd1;
                st_nxt = iate_pkg::S_RUN;
              end else res_nxt.result_value = acc_nxt;
            end
          end
          iate_pkg::OP_REVERSE: begin
            if (!j_r[4] && i_r < j_r) begin
              we_a = 1'b1; wa_a = i_r[3:0]; wd_a = rd_j;
              we_b = 1'b1; wa_b = j_r[3:0]; wd_b = rd_i;
              i_nxt = i_r + 5'd1;
              j_nxt = j_r - 5'd1;
              st_nxt = iate_pkg::S_RUN;
            end
          end
          default: res_nxt.status = iate_pkg::ST_RANGE;
        endcase
      end
      iate_pkg::S_SWAP: begin
        // Move-to-front: hit goes to slot 0, old slot 0 to the hit's place.
        // A hit already at slot 0 needs only the one write.
        we_a = (i_r != 5'd0); wa_a = i_r[3:0]; wd_a = mem[0];
        we_b = 1'b1; wa_b = 4'd0; wd_b = tmp_r;
        res_nxt.current_length = cnt_r;
        st_nxt = iate_pkg::S_DONE;
      end
      iate_pkg::S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = iate_pkg::S_IDLE;
      end
      default: st_nxt = iate_pkg::S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'd16) else $error("length above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != iate_pkg::S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(st_r) == iate_pkg::S_RUN))
    else $error("length changed outside run");
`endif
endmodule
`default_nettype wire
